// ----- rtl/core/swact_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Shared constants, field widths, the mode type and the sigmoid knot table
// for the Swish unit. No dependencies.

package swact_pkg;

  // Data format: signed Q4.12 elements.
  localparam int DATA_W           = 16;
  localparam int FRAC_BITS        = 12;

  // Sigmoid table: SIGMOID_SEGMENTS linear pieces over [-8, 8), knots in Q0.16.
  localparam int SIGMOID_SEGMENTS = 64;
  localparam int SIG_BITS         = 16;
  localparam int IDX_W            = $clog2(SIGMOID_SEGMENTS);
  // Table span is 16 << FRAC_BITS, so one segment covers 2**SEG_SHIFT codes.
  localparam int SEG_SHIFT        = FRAC_BITS + 4 - IDX_W;
  localparam int RANGE_W          = ((DATA_W > FRAC_BITS + 4) ? DATA_W : FRAC_BITS + 4) + 2;
  localparam int TBL_OFFSET       = 8 * (2 ** FRAC_BITS);
  localparam int TBL_SPAN         = 16 * (2 ** FRAC_BITS);

  // Internal widths: f = x*s, 1 - f, g = f + s*(1 - f), dy*g after rounding.
  localparam int ONE_Q            = 2 ** FRAC_BITS;
  localparam int F_W              = DATA_W + 1;
  localparam int OMF_W            = ((F_W > FRAC_BITS + 1) ? F_W : FRAC_BITS + 1) + 1;
  localparam int G_W              = OMF_W + 2;
  localparam int R_W              = DATA_W + G_W - FRAC_BITS;

  localparam int SAT_MAX          = (2 ** (DATA_W - 1)) - 1;
  localparam int SAT_MIN          = -(2 ** (DATA_W - 1));

  typedef enum logic {
    MODE_FWD = 1'b0,
    MODE_BWD = 1'b1
  } mode_t;

  // Knot i = round(65536 * sigmoid(-8 + i/4)).
  localparam logic [SIG_BITS-1:0] SIG_KNOT [SIGMOID_SEGMENTS+1] = '{
    16'd22,    16'd28,    16'd36,    16'd47,    16'd60,    16'd77,    16'd98,    16'd126,
    16'd162,   16'd208,   16'd267,   16'd342,   16'd439,   16'd562,   16'd720,   16'd922,
    16'd1179,  16'd1506,  16'd1921,  16'd2446,  16'd3108,  16'd3938,  16'd4971,  16'd6249,
    16'd7812,  16'd9702,  16'd11955, 16'd14595, 16'd17625, 16'd21025, 16'd24743, 16'd28693,
    16'd32768,
    16'd36843, 16'd40793, 16'd44511, 16'd47911, 16'd50941, 16'd53581, 16'd55834, 16'd57724,
    16'd59287, 16'd60565, 16'd61598, 16'd62428, 16'd63090, 16'd63615, 16'd64030, 16'd64357,
    16'd64614, 16'd64816, 16'd64974, 16'd65097, 16'd65194, 16'd65269, 16'd65328, 16'd65374,
    16'd65410, 16'd65438, 16'd65459, 16'd65476, 16'd65489, 16'd65500, 16'd65508, 16'd65514
  };

endpackage

`default_nettype wire

// ----- rtl/core/swact_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Request channel into the Swish unit: mode, x and upstream gradient.
// Depends on swact_pkg.

interface swact_in_if;
  import swact_pkg::*;

  logic                     valid;
  logic                     ready;
  mode_t                    mode;
  logic signed [DATA_W-1:0] x_value;
  logic signed [DATA_W-1:0] grad_in;

  modport source (output valid, output mode, output x_value, output grad_in, input ready);
  modport sink   (input valid, input mode, input x_value, input grad_in, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/swact_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Result channel out of the Swish unit.
// Depends on swact_pkg.

interface swact_out_if;
  import swact_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] result_value;

  modport source (output valid, output result_value, input ready);
  modport sink   (input valid, input result_value, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/swish_activation_fwd_bwd.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Swish (SiLU) forward / backward unit, five-stage pipeline.
// Depends on swact_pkg, swact_in_if and swact_out_if.
//
//   port   dir   payload                         request taken when
//   -----  ----  ------------------------------  ------------------------
//   elem   in    mode, x_value, grad_in (Q4.12)  elem.valid & elem.ready
//   res    out   result_value (Q4.12, sat.)      res.valid  & res.ready
//
// Throughput: one request per clock while the output is not stalled. A result
// reaches res.valid after passing through the five register stages (table
// read, interpolation multiply, x*s multiply, s*(1-f) multiply, dy*g
// multiply and saturate).
// Reset (rst, synchronous) clears only the stage valid bits.
// Stalls: each stage holds while the stage after it is full and not moving;
// empty stages keep filling, so requests are still taken while a finished
// result waits at the output. Ready is a short combinational chain.

module swish_activation_fwd_bwd (
  input  wire          clk,
  input  wire          rst,
  swact_in_if.sink     elem,
  swact_out_if.source  res
);
  import swact_pkg::*;

  localparam int NUM_STAGES = 5;
  localparam int OCC_W      = $clog2(NUM_STAGES + 1);

  // Stage control: vld[k] marks stage k+1 full, adv[k] lets it load.
  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES-1:0] adv;

  always_comb begin
    adv[NUM_STAGES-1] = !vld[NUM_STAGES-1] || res.ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign elem.ready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= elem.valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: table position of x, read the two knots around it.
  // Outside [-8, 8) both reads hit the end knot, so the slope is zero.
  // ---------------------------------------------------------------------
  logic signed [RANGE_W-1:0] a_u;
  logic                      a_under;
  logic                      a_over;
  logic [IDX_W-1:0]          a_idx;
  logic [IDX_W:0]            a_lo_sel;
  logic [IDX_W:0]            a_hi_sel;
  logic [SIG_BITS-1:0]       a_s0;
  logic [SIG_BITS-1:0]       a_s1;

  always_comb begin
    a_u     = RANGE_W'(elem.x_value) + RANGE_W'(TBL_OFFSET);
    a_under = a_u[RANGE_W-1];
    a_over  = !a_under && (a_u[RANGE_W-2:0] >= (RANGE_W-1)'(TBL_SPAN));
    a_idx   = a_u[SEG_SHIFT +: IDX_W];
    if (a_under) begin
      a_lo_sel = '0;
      a_hi_sel = '0;
    end else if (a_over) begin
      a_lo_sel = (IDX_W+1)'(SIGMOID_SEGMENTS);
      a_hi_sel = (IDX_W+1)'(SIGMOID_SEGMENTS);
    end else begin
      a_lo_sel = {1'b0, a_idx};
      a_hi_sel = {1'b0, a_idx} + (IDX_W+1)'(1);
    end
    a_s0 = SIG_KNOT[a_lo_sel];
    a_s1 = SIG_KNOT[a_hi_sel];
  end

  mode_t                    st1_mode;
  logic signed [DATA_W-1:0] st1_x;
  logic signed [DATA_W-1:0] st1_dy;
  logic [SIG_BITS-1:0]      st1_s0;
  logic [SIG_BITS-1:0]      st1_ds;
  logic [SEG_SHIFT-1:0]     st1_rem;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      st1_mode <= elem.mode;
      st1_x    <= elem.x_value;
      st1_dy   <= elem.grad_in;
      st1_s0   <= a_s0;
      st1_ds   <= a_s1 - a_s0;
      st1_rem  <= a_u[SEG_SHIFT-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: linear interpolation, s = s0 + round(ds * rem / segment).
  // ds is never negative, so the shift is the plain quotient.
  // ---------------------------------------------------------------------
  logic [SIG_BITS+SEG_SHIFT-1:0] b_prod;
  logic [SIG_BITS+SEG_SHIFT:0]   b_round;
  logic [SIG_BITS-1:0]           b_sig;

  always_comb begin
    b_prod  = st1_ds * st1_rem;
    b_round = {1'b0, b_prod} + (SIG_BITS+SEG_SHIFT+1)'(2 ** (SEG_SHIFT - 1));
    b_sig   = st1_s0 + SIG_BITS'(b_round >> SEG_SHIFT);
  end

  mode_t                    st2_mode;
  logic signed [DATA_W-1:0] st2_x;
  logic signed [DATA_W-1:0] st2_dy;
  logic [SIG_BITS-1:0]      st2_sig;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      st2_mode <= st1_mode;
      st2_x    <= st1_x;
      st2_dy   <= st1_dy;
      st2_sig  <= b_sig;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: f = x * s, rounded half up (floor of product + half).
  // ---------------------------------------------------------------------
  logic signed [DATA_W+SIG_BITS:0] c_xs;
  logic signed [DATA_W+SIG_BITS:0] c_round;
  logic signed [F_W-1:0]           c_f;

  always_comb begin
    c_xs    = st2_x * $signed({1'b0, st2_sig});
    c_round = c_xs + (DATA_W+SIG_BITS+1)'(2 ** (SIG_BITS - 1));
    c_f     = c_round[SIG_BITS +: F_W];
  end

  mode_t                    st3_mode;
  logic signed [DATA_W-1:0] st3_dy;
  logic [SIG_BITS-1:0]      st3_sig;
  logic signed [F_W-1:0]    st3_f;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      st3_mode <= st2_mode;
      st3_dy   <= st2_dy;
      st3_sig  <= st2_sig;
      st3_f    <= c_f;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: g = f + round(s * (1 - f)). Unsaturated.
  // ---------------------------------------------------------------------
  logic signed [OMF_W-1:0]          d_omf;
  logic signed [SIG_BITS+OMF_W:0]   d_t;
  logic signed [SIG_BITS+OMF_W:0]   d_round;
  logic signed [G_W-1:0]            d_g;

  always_comb begin
    d_omf   = OMF_W'(ONE_Q) - OMF_W'(st3_f);
    d_t     = $signed({1'b0, st3_sig}) * d_omf;
    d_round = d_t + (SIG_BITS+OMF_W+1)'(2 ** (SIG_BITS - 1));
    d_g     = G_W'(st3_f) + G_W'($signed(d_round[SIG_BITS +: OMF_W+1]));
  end

  mode_t                    st4_mode;
  logic signed [DATA_W-1:0] st4_dy;
  logic signed [F_W-1:0]    st4_f;
  logic signed [G_W-1:0]    st4_g;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      st4_mode <= st3_mode;
      st4_dy   <= st3_dy;
      st4_f    <= st3_f;
      st4_g    <= d_g;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 5: backward takes round(dy * g), forward takes f; saturate.
  // ---------------------------------------------------------------------
  logic signed [DATA_W+G_W-1:0] e_p;
  logic signed [DATA_W+G_W-1:0] e_round;
  logic signed [R_W-1:0]        e_r;
  logic signed [R_W-1:0]        e_sel;
  logic signed [DATA_W-1:0]     e_sat;

  always_comb begin
    e_p     = st4_dy * st4_g;
    e_round = e_p + (DATA_W+G_W)'(2 ** (FRAC_BITS - 1));
    e_r     = e_round[FRAC_BITS +: R_W];
    e_sel   = (st4_mode == MODE_BWD) ? e_r : R_W'(st4_f);
    if (e_sel > R_W'(SAT_MAX)) begin
      e_sat = DATA_W'(SAT_MAX);
    end else if (e_sel < R_W'(SAT_MIN)) begin
      e_sat = DATA_W'(SAT_MIN);
    end else begin
      e_sat = e_sel[DATA_W-1:0];
    end
  end

  logic signed [DATA_W-1:0] st5_result;

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      st5_result <= e_sat;
    end
  end

  assign res.valid        = vld[NUM_STAGES-1];
  assign res.result_value = st5_result;

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  logic             in_fire;
  logic             out_fire;
  logic [OCC_W-1:0] occ;

  assign in_fire  = elem.valid && elem.ready;
  assign out_fire = res.valid && res.ready;
  assign occ      = OCC_W'($countones(vld));

  // Pipeline occupancy moves only with accepted requests and taken results.
  assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (occ == $past(occ) + OCC_W'($past(in_fire)) - OCC_W'($past(out_fire))))
    else $error("pipeline occupancy lost or gained an item");

  // Interpolated sigmoid stays between its two knots.
  assert property (@(posedge clk) disable iff (rst)
    (vld[0] && adv[1]) |=>
      ((st2_sig >= $past(st1_s0)) &&
       ({1'b0, st2_sig} <= ({1'b0, $past(st1_s0)} + {1'b0, $past(st1_ds)}))))
    else $error("interpolated sigmoid outside its segment");

  // Sigmoid never leaves the table's end values.
  assert property (@(posedge clk) disable iff (rst)
    vld[1] |-> ((st2_sig >= SIG_KNOT[0]) && (st2_sig <= SIG_KNOT[SIGMOID_SEGMENTS])))
    else $error("sigmoid value out of table range");

endmodule

`default_nettype wire
